FILE: hdl/wildcard_byte_signature_scan_core_macros.svh
// assertion macros for the wildcard byte signature scan core
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_CORE_MACROS_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold in the same cycle
`define WBSS_ASSERT_NOW(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("wbss: same-cycle check failed");

// trigger implies consequence in the next cycle
`define WBSS_ASSERT_NEXT(label, ck, rn, trig, conseq) \
    label: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (conseq)) \
        else $error("wbss: next-cycle check failed");

`else

`define WBSS_ASSERT_NOW(label, ck, rn, cond)
`define WBSS_ASSERT_NEXT(label, ck, rn, trig, conseq)

`endif

`endif

FILE: hdl/wbss_pkg.sv
// shared constants and types for the wildcard byte signature scan core
package wbss_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
    localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int REG_BYTES   = 16;
    localparam int LEN_W       = 5;
    localparam int POS_W       = 32;
    localparam int RANGE_W     = 8;
    localparam int CALC_W      = 8;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
    localparam logic [RANGE_W-1:0] RANGE_MAX = {RANGE_W{1'b1}};
    localparam logic [FILL_W-1:0]  FILL_MAX  = FILL_W'(MAX_PATTERN);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_CARE_MASK    = 2'd2,
        CFG_LENGTH       = 2'd3
    } cfg_reg_t;

    // window of recent bytes, highest entry newest
    typedef logic [MAX_PATTERN-1:0][7:0] byte_window_t;

    typedef struct packed {
        logic [63:0]          pattern_low;
        logic [63:0]          pattern_high;
        logic [REG_BYTES-1:0] care;
        logic [LEN_W-1:0]     length;
    } sig_cfg_t;

    typedef struct packed {
        logic [FILL_W-1:0]  fill;
        logic [POS_W-1:0]   pos;
        logic [RANGE_W-1:0] range_idx;
        logic               end_pending;
    } scan_state_t;

endpackage

FILE: hdl/wbss_window.sv
// byte window and range/offset counters, updated on every accepted word
module wbss_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 range_start,
    input  logic                 scan_end,
    output wbss_pkg::byte_window_t window,
    output wbss_pkg::scan_state_t  state
);
    import wbss_pkg::*;

    byte_window_t window_reg;
    byte_window_t window_next;
    scan_state_t  state_reg;
    scan_state_t  state_next;

    // counter update: a pending scan end restarts from reset values
    always_comb
    begin
        logic [FILL_W-1:0]  fill;
        logic [POS_W-1:0]   pos;
        logic [RANGE_W-1:0] rng;
        fill = state_reg.end_pending ? '0 : state_reg.fill;
        pos  = state_reg.end_pending ? '0 : state_reg.pos;
        rng  = state_reg.end_pending ? '0 : state_reg.range_idx;
        if (range_start)
        begin
            if (pos != '0 && rng < RANGE_MAX)
                rng = rng + RANGE_W'(1);
            fill = '0;
            pos  = '0;
        end
        if (fill < FILL_MAX)
            fill = fill + FILL_W'(1);
        if (pos < POS_MAX)
            pos = pos + POS_W'(1);
        state_next.fill        = fill;
        state_next.pos         = pos;
        state_next.range_idx   = rng;
        state_next.end_pending = scan_end;
    end

    // shift the new byte in at the top
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN - 1; j++)
            window_next[j] = window_reg[j + 1];
        window_next[MAX_PATTERN - 1] = data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // entries below the fill count are never compared
    always_ff @(posedge clk)
    begin
        if (accept)
            window_reg <= window_next;
    end

    assign window = window_reg;
    assign state  = state_reg;

endmodule

FILE: hdl/wbss_match.sv
// parallel wildcard compare of the window tail against the signature
module wbss_match (
    input  wbss_pkg::byte_window_t       window,
    input  logic [wbss_pkg::FILL_W-1:0]  fill,
    input  wbss_pkg::sig_cfg_t           cfg,
    output logic                         hit
);
    import wbss_pkg::*;

    logic [2*64-1:0]   pattern;
    logic [CALC_W-1:0] base;
    logic              len_ok;
    logic              mismatch;

    assign pattern = {cfg.pattern_high, cfg.pattern_low};
    assign base    = CALC_W'(MAX_PATTERN) - CALC_W'(cfg.length);

    // length must be nonzero, fit the window and be covered by the fill
    assign len_ok = (cfg.length != '0)
                 && (CALC_W'(cfg.length) <= CALC_W'(MAX_PATTERN))
                 && (CALC_W'(fill) >= CALC_W'(cfg.length));

    // byte k of the signature lines up with window entry base + k
    always_comb
    begin
        logic [CALC_W-1:0] idx;
        logic [7:0]        have;
        mismatch = 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            idx  = base + CALC_W'(k);
            have = window[idx[WIN_IDX_W-1:0]];
            if (k < REG_BYTES && CALC_W'(k) < CALC_W'(cfg.length)
                && cfg.care[k % REG_BYTES]
                && have != pattern[(k % REG_BYTES) * 8 +: 8])
                mismatch = 1'b1;
        end
    end

    assign hit = len_ok && !mismatch;

endmodule

FILE: hdl/wildcard_byte_signature_scan_core.sv
// Wildcard byte signature scan core, top level.
// Each accepted input word is held in the window/counter register; its compare
// result is then written into the output register when that register is free.
// Throughput: one byte per cycle; the input stalls only while a result waits
// in the stalled output register and the next word under compare also has a result.
// Reset clears the configuration to zero and returns the scan state to start.
`include "wildcard_byte_signature_scan_core_macros.svh"

module wildcard_byte_signature_scan_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [wbss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbss_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             range_start,
    input  logic                             scan_end,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             found,
    output logic [wbss_pkg::RANGE_W-1:0]     range_number,
    output logic [wbss_pkg::POS_W-1:0]       match_offset
);
    import wbss_pkg::*;

    sig_cfg_t     cfg_reg;
    byte_window_t window;
    scan_state_t  state;
    logic         hit;

    logic               eval_valid_reg;
    logic               reported_reg;
    logic               out_valid_reg;
    logic               found_reg;
    logic [RANGE_W-1:0] range_number_reg;
    logic [POS_W-1:0]   match_offset_reg;

    logic             in_accept;
    logic             hit_new;
    logic             produce;
    logic             out_free;
    logic             retire;
    logic [POS_W-1:0] offset;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LOW:  cfg_reg.pattern_low  <= cfg_data[63:0];
                CFG_PATTERN_HIGH: cfg_reg.pattern_high <= cfg_data[63:0];
                CFG_CARE_MASK:    cfg_reg.care         <= cfg_data[REG_BYTES-1:0];
                CFG_LENGTH:       cfg_reg.length       <= cfg_data[LEN_W-1:0];
            endcase
        end
    end

    wbss_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .data_byte   (data_byte),
        .range_start (range_start),
        .scan_end    (scan_end),
        .window      (window),
        .state       (state)
    );

    wbss_match u_match (
        .window (window),
        .fill   (state.fill),
        .cfg    (cfg_reg),
        .hit    (hit)
    );

    // handshake: the word under compare retires unless its result is blocked
    // a scan end gives a not-found word only when no match was reported yet
    assign hit_new   = eval_valid_reg && hit && !reported_reg;
    assign produce   = eval_valid_reg && (hit_new || (state.end_pending && !reported_reg));
    assign out_free  = !out_valid_reg || !out_stall;
    assign retire    = eval_valid_reg && (!produce || out_free);
    assign in_stall  = eval_valid_reg && !retire;
    assign in_accept = in_valid && !in_stall;

    // start offset of the match, pinned once the position saturates
    assign offset = (state.pos == POS_MAX) ? POS_MAX
                                           : state.pos - POS_W'(cfg_reg.length);

    // compare stage valid and first-match flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_valid_reg <= 1'b0;
            reported_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
                eval_valid_reg <= 1'b1;
            else if (retire)
                eval_valid_reg <= 1'b0;
            if (retire)
                reported_reg <= state.end_pending ? 1'b0 : (reported_reg | hit_new);
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (retire && produce)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (retire && produce)
        begin
            found_reg        <= hit_new;
            range_number_reg <= hit_new ? state.range_idx : '0;
            match_offset_reg <= hit_new ? offset : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign range_number = range_number_reg;
    assign match_offset = match_offset_reg;

    // checks
    `WBSS_ASSERT_NOW(a_no_overwrite, clk, rst_n, !(retire && produce && out_valid_reg && out_stall))
    `WBSS_ASSERT_NOW(a_fill_bounded, clk, rst_n, (state.fill <= FILL_MAX) && (POS_W'(state.fill) <= state.pos))
    `WBSS_ASSERT_NEXT(a_hit_reported, clk, rst_n, retire && hit_new, out_valid_reg && found_reg)

endmodule
